// ----- sv/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, register indexes and byte-level functions for the AES-256 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int KEY_WORDS   = 8;
  localparam int SCHED_WORDS = 4 * (ROUND_COUNT + 1);
  localparam int RK_AW       = $clog2(SCHED_WORDS);
  localparam int RND_W       = $clog2(ROUND_COUNT + 1);

  // configuration register indexes
  localparam logic [1:0] REG_KEY_0 = 2'd0;
  localparam logic [1:0] REG_KEY_1 = 2'd1;
  localparam logic [1:0] REG_KEY_2 = 2'd2;
  localparam logic [1:0] REG_KEY_3 = 2'd3;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  // controller to datapath
  typedef struct packed {
    logic             exp_load;    // load key words 0..7 into schedule window
    logic             exp_step;    // compute next schedule word
    logic [RK_AW-1:0] exp_idx;     // schedule word index being written
    logic             blk_load;    // load block and do initial key add
    logic             rnd_step;    // one cipher round
    logic             rnd_last;    // final round, no mix columns
    logic [RND_W-1:0] rnd;         // round key index used in this cycle
    logic             dec;
  } aes_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- sv/aes_ctrl.sv -----
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer for key expansion, the round loop and the output handshake.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              key_dirty,
  output aes_pkg::aes_cmd_t cmd
);
  import aes_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXPAND, S_ROUND} state_t;

  state_t           state_r, state_nxt;
  logic [RK_AW-1:0] idx_r, idx_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             dec_r, dec_nxt;
  logic             pend_r, pend_nxt;     // block waiting for expansion
  logic             outv_r, outv_nxt;
  logic             ok_r, ok_nxt;         // schedule valid for current key
  logic             take;
  logic             out_free;

  assign out_free  = !outv_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || pend_r || !out_free;
  assign take      = in_valid && !in_stall;
  assign out_valid = outv_r;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.exp_idx  = idx_r;
    cmd.rnd      = rnd_r;
    cmd.dec      = take ? in_mode : dec_r;
    cmd.exp_load = take && (key_dirty || !ok_r);
    cmd.blk_load = take;
    cmd.exp_step = (state_r == S_EXPAND);
    cmd.rnd_step = (state_r == S_ROUND);
    cmd.rnd_last = (state_r == S_ROUND) &&
                   (dec_r ? (rnd_r == '0) : (rnd_r == RND_W'(ROUND_COUNT)));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rnd_nxt   = rnd_r;
    dec_nxt   = dec_r;
    pend_nxt  = pend_r;
    ok_nxt    = ok_r && !key_dirty;
    outv_nxt  = outv_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          dec_nxt = in_mode;
          if (key_dirty || !ok_r) begin
            state_nxt = S_EXPAND;
            idx_nxt   = RK_AW'(KEY_WORDS);
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = S_ROUND;
            rnd_nxt   = in_mode ? RND_W'(ROUND_COUNT - 1) : RND_W'(1);
          end
        end
      end
      S_EXPAND: begin
        if (idx_r == RK_AW'(SCHED_WORDS - 1)) begin
          ok_nxt    = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_ROUND;
          rnd_nxt   = dec_r ? RND_W'(ROUND_COUNT - 1) : RND_W'(1);
        end else begin
          idx_nxt = idx_r + RK_AW'(1);
        end
      end
      S_ROUND: begin
        if (cmd.rnd_last) begin
          state_nxt = S_IDLE;
          outv_nxt  = 1'b1;
        end else begin
          rnd_nxt = dec_r ? rnd_r - RND_W'(1) : rnd_r + RND_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      rnd_r   <= '0;
      dec_r   <= 1'b0;
      pend_r  <= 1'b0;
      outv_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
      dec_r   <= dec_nxt;
      pend_r  <= pend_nxt;
      outv_r  <= outv_nxt;
      ok_r    <= ok_nxt;
    end
  end

endmodule

// ----- sv/aes_datapath.sv -----
// ----------------------------------------------------------------------------
// aes_datapath
// Key registers, key schedule, round-key store and one-round-per-cycle state.
// ----------------------------------------------------------------------------
module aes_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_sel,
  input  logic [63:0]       cfg_wdata,
  input  aes_pkg::aes_in_t  in_data,
  input  aes_pkg::aes_cmd_t cmd,
  output logic              key_dirty,
  output aes_pkg::aes_out_t out_data
);
  import aes_pkg::*;

  logic [63:0]  key_r [4];
  logic         dirty_r;
  logic [31:0]  win_r [KEY_WORDS];      // last eight schedule words
  logic [7:0]   rc_r;
  logic [127:0] rk_mem [ROUND_COUNT+1]; // one full round key per entry
  logic [RND_W-1:0] wr_row;
  logic [1:0]   wr_lane;
  logic [127:0] st_r;
  logic [127:0] rk_blk;
  logic [31:0]  t, wnew;
  logic [127:0] st_in, sr, sb, mc_in, mc, rnd_out;

  assign key_dirty = dirty_r;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      dirty_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        key_r[cfg_sel] <= cfg_wdata;
        dirty_r        <= 1'b1;
      end else if (cmd.exp_load) begin
        dirty_r <= 1'b0;
      end
    end
  end

  // next schedule word
  always_comb begin
    t = win_r[KEY_WORDS-1];
    if (cmd.exp_idx[2:0] == 3'd0)
      t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
    else if (cmd.exp_idx[2:0] == 3'd4)
      t = sub_word(t);
    wnew = win_r[0] ^ t;
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_load) begin
      for (int i = 0; i < 4; i++) begin
        win_r[2*i]   <= key_r[i][63:32];
        win_r[2*i+1] <= key_r[i][31:0];
      end
      rc_r <= 8'h01;
    end else if (cmd.exp_step) begin
      for (int i = 0; i < KEY_WORDS - 1; i++) win_r[i] <= win_r[i+1];
      win_r[KEY_WORDS-1] <= wnew;
      if (cmd.exp_idx[2:0] == 3'd0) rc_r <= xtime(rc_r);
    end
  end

  // round-key store, one schedule word written per expansion step
  assign wr_row  = cmd.exp_idx[RK_AW-1:2];
  assign wr_lane = cmd.exp_idx[1:0];

  always_ff @(posedge clk) begin
    if (cmd.exp_load) begin
      rk_mem[0] <= {key_r[0], key_r[1]};
      rk_mem[1] <= {key_r[2], key_r[3]};
    end else if (cmd.exp_step) begin
      rk_mem[wr_row][127 - 32*wr_lane -: 32] <= wnew;
    end
  end

  assign rk_blk = rk_mem[cmd.rnd];

  // one round: shift rows, sub bytes, mix columns, key add; the final round skips mix columns
  always_comb begin
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3;
    logic [7:0] x;
    st_in = st_r;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (cmd.dec)
          sr[127 - 8*(r + 4*((c + r) % 4)) -: 8] = st_in[127 - 8*(r + 4*c) -: 8];
        else
          sr[127 - 8*(r + 4*c) -: 8] = st_in[127 - 8*(r + 4*((c + r) % 4)) -: 8];
      end
    for (int k = 0; k < 16; k++) begin
      x = sr[127 - 8*k -: 8];
      sb[127 - 8*k -: 8] = cmd.dec ? INV_SBOX[x] : SBOX[x];
    end
    // decrypt adds the round key before the inverse mix
    mc_in = cmd.dec ? (sb ^ rk_blk) : sb;
    mc = sb;
    for (int c = 0; c < 4; c++) begin
      a0 = mc_in[127 - 32*c -: 8];
      a1 = mc_in[119 - 32*c -: 8];
      a2 = mc_in[111 - 32*c -: 8];
      a3 = mc_in[103 - 32*c -: 8];
      b0 = xtime(a0); b1 = xtime(a1); b2 = xtime(a2); b3 = xtime(a3);
      c0 = xtime(b0); c1 = xtime(b1); c2 = xtime(b2); c3 = xtime(b3);
      if (cmd.dec) begin
        // 0e 0b 0d 09 via 2x, 4x, 8x terms
        mc[127 - 32*c -: 8] = (xtime(c0)^c0^b0) ^ (xtime(c1)^b1^a1) ^
                              (xtime(c2)^c2^a2) ^ (xtime(c3)^a3);
        mc[119 - 32*c -: 8] = (xtime(c0)^a0) ^ (xtime(c1)^c1^b1) ^
                              (xtime(c2)^b2^a2) ^ (xtime(c3)^c3^a3);
        mc[111 - 32*c -: 8] = (xtime(c0)^c0^a0) ^ (xtime(c1)^a1) ^
                              (xtime(c2)^c2^b2) ^ (xtime(c3)^b3^a3);
        mc[103 - 32*c -: 8] = (xtime(c0)^b0^a0) ^ (xtime(c1)^c1^a1) ^
                              (xtime(c2)^a2) ^ (xtime(c3)^c3^b3);
      end else begin
        mc[127 - 32*c -: 8] = b0 ^ (b1 ^ a1) ^ a2 ^ a3;
        mc[119 - 32*c -: 8] = a0 ^ b1 ^ (b2 ^ a2) ^ a3;
        mc[111 - 32*c -: 8] = a0 ^ a1 ^ b2 ^ (b3 ^ a3);
        mc[103 - 32*c -: 8] = (b0 ^ a0) ^ a1 ^ a2 ^ b3;
      end
    end
    if (cmd.rnd_last)  rnd_out = sb ^ rk_blk;
    else if (cmd.dec)  rnd_out = mc;
    else               rnd_out = mc ^ rk_blk;
  end

  // state register; initial key add uses round 0 or the last round key
  always_ff @(posedge clk) begin
    if (cmd.blk_load && !cmd.exp_load)
      st_r <= {in_data.block_high, in_data.block_low} ^
              (in_data.mode ? rk_mem[ROUND_COUNT] : rk_mem[0]);
    else if (cmd.blk_load)
      st_r <= {in_data.block_high, in_data.block_low};
    else if (cmd.exp_step && cmd.exp_idx == RK_AW'(SCHED_WORDS - 1))
      st_r <= st_r ^ (cmd.dec ? {rk_mem[ROUND_COUNT][127:32], wnew} : rk_mem[0]);
    else if (cmd.rnd_step)
      st_r <= rnd_out;
  end

  assign out_data.result_high = st_r[127:64];
  assign out_data.result_low  = st_r[63:0];

endmodule

// ----- sv/aes256_block_cipher_core.sv -----
// ----------------------------------------------------------------------------
// aes256_block_cipher_core
// AES-256 single-block encrypt/decrypt with on-chip key expansion.
// ----------------------------------------------------------------------------
// each block runs one round per cycle from accept to result
// the first block after reset or a key write is preceded by key expansion,
//   one schedule word per cycle through the expansion unit
// blocks do not overlap: a new block waits until the core is idle and its result is taken, set by the single round unit
// reset: synchronous active low, key registers cleared to zero
module aes256_block_cipher_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aes_pkg::aes_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output aes_pkg::aes_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import aes_pkg::*;

  aes_cmd_t cmd;
  logic     key_dirty;

  assign cfg_ready = 1'b1;

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_dirty (key_dirty),
    .cmd       (cmd)
  );

  aes_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .key_dirty (key_dirty),
    .out_data  (out_data)
  );

endmodule

// ----- tb/aes256_block_cipher_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes256_block_cipher_checker
// Watches the key write, block and result channels of the AES-256 core, runs
// its own cipher on each accepted block and compares every result beat.
// ----------------------------------------------------------------------------
module aes256_block_cipher_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  aes_pkg::aes_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  aes_pkg::aes_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output int                err_count,
  output int                pending_blocks,
  output int                result_count
);
  import aes_pkg::*;

  typedef logic [7:0] state_t [16];

  logic [63:0]    key_reg [4];
  logic [31:0]    sched [SCHED_WORDS];
  aes_out_t       cipher_q [$];
  logic [7:0]     inv_box [256];

  // inverse substitution built from the forward table
  initial begin
    for (int k = 0; k < 256; k++) inv_box[SBOX[k]] = k[7:0];
  end

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic state_t mix(input state_t s, input logic [7:0] m [4]);
    state_t o;
    for (int c = 0; c < 4; c++)
      for (int rr = 0; rr < 4; rr++) begin
        o[rr+4*c] = 8'h00;
        for (int k = 0; k < 4; k++) o[rr+4*c] ^= gmul(m[(k+4-rr)%4], s[k+4*c]);
      end
    return o;
  endfunction

  // full key schedule from the key registers
  task automatic build_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      sched[2*i]   = key_reg[i][63:32];
      sched[2*i+1] = key_reg[i][31:0];
    end
    for (int i = KEY_WORDS; i < SCHED_WORDS; i++) begin
      t = sched[i-1];
      if (i % KEY_WORDS == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % KEY_WORDS == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-KEY_WORDS] ^ t;
    end
  endtask

  function automatic aes_out_t cipher_block(input aes_in_t blk);
    state_t     s;
    state_t     t;
    logic [7:0] m [4];
    logic       dec;
    aes_out_t   r;
    int         rnd;
    dec = (blk.mode == MODE_DEC);
    for (int k = 0; k < 8; k++) begin
      s[k]   = blk.block_high[63-8*k -: 8];
      s[k+8] = blk.block_low[63-8*k -: 8];
    end
    if (dec) begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int step = 0; step <= ROUND_COUNT; step++) begin
      rnd = dec ? ROUND_COUNT - step : step;
      if (step > 0) begin
        // shift rows then substitute (order commutes)
        t = s;
        for (int rr = 1; rr < 4; rr++)
          for (int c = 0; c < 4; c++)
            if (dec) s[rr+4*((c+rr)%4)] = t[rr+4*c];
            else s[rr+4*c] = t[rr+4*((c+rr)%4)];
        for (int k = 0; k < 16; k++) s[k] = dec ? inv_box[s[k]] : SBOX[s[k]];
      end
      // mix columns before the key add when encrypting
      if (!dec && step > 0 && step < ROUND_COUNT) s = mix(s, m);
      for (int c = 0; c < 4; c++)
        for (int rr = 0; rr < 4; rr++)
          s[rr+4*c] ^= sched[4*rnd+c][31-8*rr -: 8];
      if (dec && step > 0 && step < ROUND_COUNT) s = mix(s, m);
    end
    for (int k = 0; k < 8; k++) begin
      r.result_high[63-8*k -: 8] = s[k];
      r.result_low[63-8*k -: 8]  = s[k+8];
    end
    return r;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    aes_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      build_schedule();
      cipher_q.delete();
      err_count      <= 0;
      result_count   <= 0;
      pending_blocks <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_reg[cfg_index] = cfg_data;
        build_schedule();
      end
      if (in_valid && !in_stall) cipher_q.push_back(cipher_block(in_data));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (cipher_q.size() == 0) begin
          if (err_count < 10) $display("ERROR: result beat %h with none expected", out_data);
          err_count <= err_count + 1;
        end else begin
          want = cipher_q.pop_front();
          if (want.result_high !== out_data.result_high ||
              want.result_low !== out_data.result_low) begin
            if (err_count < 10)
              $display("ERROR: result mismatch exp %h_%h got %h_%h", want.result_high,
                       want.result_low, out_data.result_high, out_data.result_low);
            err_count <= err_count + 1;
          end
        end
      end
      pending_blocks <= cipher_q.size();
    end
  end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives key writes and encrypt/decrypt blocks into the AES-256 core with
// bursty input and random output stalls; the checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  import aes_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  RANDOM_BLOCKS = 830;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  aes_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aes_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_KEY_0;
  logic [63:0] cfg_data = '0;
  int          err_count, pending_blocks, result_count;
  int          cycle_count = 0;
  int          hold_off = 0;
  bit          long_hold = 1'b0;
  bit          hold_used = 1'b0;
  int          sent_blocks = 0;

  always #5 clk = ~clk;

  aes256_block_cipher_core i_dut (.*);
  aes256_block_cipher_checker i_checker (.*);

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else if (long_hold && !hold_used) begin
      out_stall <= 1'b1;
      hold_off  <= 300;
      hold_used <= 1'b1;
    end else begin
      case (cycle_count / 2000 % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo);
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, block_high: hi, block_low: lo};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_blocks++;
  endtask

  task automatic gap_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_key(REG_KEY_0, k0);
    write_key(REG_KEY_1, k1);
    write_key(REG_KEY_2, k2);
    write_key(REG_KEY_3, k3);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key (all zero) first, then the standard test key
    send_block(MODE_ENC, '0, '0);
    send_block(MODE_DEC, '0, '0);
    send_block(MODE_ENC, '1, '1);
    drain();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(MODE_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    send_block(MODE_DEC, '1, '0);
    send_block(MODE_ENC, 64'h8000000000000000, 64'h0000000000000001);
    drain();
    // all-ones key, then an all-zero key written explicitly
    load_key('1, '1, '1, '1);
    send_block(MODE_ENC, '0, '1);
    send_block(MODE_DEC, '1, '1);
    drain();
    load_key('0, '0, '0, '0);
    send_block(MODE_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(MODE_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();

    // long receiver hold-off while blocks keep coming
    load_key(rand64(), rand64(), rand64(), rand64());
    long_hold <= 1'b1;
    for (int i = 0; i < 12; i++) send_block(1'($urandom_range(0, 1)), rand64(), rand64());
    drain();

    // random phases with a fresh key, single register rewrites now and then
    for (int i = 0; i < RANDOM_BLOCKS; i++) begin
      if (i % 100 == 99) begin
        drain();
        if ($urandom_range(0, 1)) begin
          load_key(rand64(), rand64(), rand64(), rand64());
        end else begin
          write_key(2'($urandom_range(0, 3)), rand64());
          cfg_valid <= 1'b0;
        end
      end
      burst = $urandom_range(0, 2);
      send_block(1'($urandom_range(0, 1)), rand64(), rand64());
      if (i % 200 < 100 && burst == 0) gap_cycles($urandom_range(1, 30));
      else if (burst == 0) gap_cycles(1);
    end
    drain();

    $display("sent %0d blocks, checked %0d results over several keys, both modes",
             sent_blocks, result_count);
    if (err_count == 0 && result_count == sent_blocks)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/aes_pkg.sv
sv/aes_ctrl.sv
sv/aes_datapath.sv
sv/aes256_block_cipher_core.sv
tb/aes256_block_cipher_checker.sv
tb/testbench.sv
